### rtl/hsb_pkg.sv
package hsb_pkg;

    localparam logic [1:0] CFG_HUE_SHIFT    = 2'd0;
    localparam logic [1:0] CFG_DESATURATION = 2'd1;
    localparam logic [1:0] CFG_BRIGHTNESS   = 2'd2;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

    // Internal pixel: channel 0 is red, 1 green, 2 blue.
    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [7:0]      alpha;
    } t_rgba;

    // Settings derived from the registers, shared by the desaturation and hue stages.
    typedef struct packed {
        logic       bypass;
        logic [7:0] desat;
        logic [1:0] hue_sector;
        logic [8:0] hue_ofs;
    } t_ctrl;

endpackage

### rtl/hsb_bright.sv
module hsb_bright (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  hsb_pkg::t_pix_in    i_pix,
    input  logic signed [7:0]   i_bright,
    output logic                o_valid,
    output hsb_pkg::t_rgba      o_pix
);

    logic                 r_valid;
    hsb_pkg::t_rgba       r_pix;
    hsb_pkg::t_rgba       n_pix;
    logic [7:0]           w_weight;
    logic [14:0]          w_add;
    logic [2:0][7:0]      w_in;
    logic [14:0]          w_acc [3];

    assign w_in = {i_pix.blue_in, i_pix.green_in, i_pix.red_in};

    // Blend toward white for a positive setting, toward black otherwise.
    always_comb begin
        if (!i_bright[7]) begin
            w_weight = 8'd128 - 8'(i_bright);
            w_add    = 15'(8'd255 * 8'(i_bright));
        end else begin
            w_weight = 8'd128 + 8'(i_bright);
            w_add    = '0;
        end
        for (int i = 0; i < 3; i++) begin
            w_acc[i]    = 15'(w_in[i] * w_weight) + w_add;
            n_pix.ch[i] = w_acc[i][14:7];
        end
        n_pix.alpha = i_pix.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

### rtl/hsb_desat.sv
module hsb_desat (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  hsb_pkg::t_ctrl    i_ctrl,
    input  logic              i_valid,
    input  hsb_pkg::t_rgba    i_pix,
    output logic              o_valid,
    output logic              o_grey,
    output hsb_pkg::t_rgba    o_pix
);

    logic              r_valid_a;
    hsb_pkg::t_rgba    r_pix_a;
    logic [7:0]        r_avg;
    logic              r_grey_a;
    logic              r_valid_b;
    hsb_pkg::t_rgba    r_pix_b;
    logic              r_grey_b;
    hsb_pkg::t_rgba    n_pix_b;
    logic [9:0]        w_sum;
    logic [19:0]       w_prod;
    logic [8:0]        w_keep;
    logic [15:0]       w_acc [3];

    // Divide by three with a reciprocal; exact for sums up to 765.
    assign w_sum  = 10'(i_pix.ch[0]) + 10'(i_pix.ch[1]) + 10'(i_pix.ch[2]);
    assign w_prod = w_sum * 10'd683;
    assign w_keep = 9'd256 - 9'(i_ctrl.desat);

    always_comb begin
        n_pix_b = r_pix_a;
        for (int i = 0; i < 3; i++) begin
            w_acc[i] = 16'(r_pix_a.ch[i] * w_keep) + 16'(i_ctrl.desat * r_avg);
            if (!r_grey_a && !i_ctrl.bypass) begin
                n_pix_b.ch[i] = w_acc[i][15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
        if (i_en) begin
            r_pix_a  <= i_pix;
            r_avg    <= w_prod[18:11];
            r_grey_a <= (i_pix.ch[0] == i_pix.ch[1]) && (i_pix.ch[1] == i_pix.ch[2]);
            r_pix_b  <= n_pix_b;
            r_grey_b <= r_grey_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_grey  = r_grey_b;
    assign o_pix   = r_pix_b;

endmodule

### rtl/hsb_hue.sv
module hsb_hue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hsb_pkg::t_ctrl     i_ctrl,
    input  logic               i_valid,
    input  logic               i_grey,
    input  hsb_pkg::t_rgba     i_pix,
    output logic               o_valid,
    output hsb_pkg::t_pix_out  o_pix
);

    // Rotation and min/max.
    logic              r_v4;
    hsb_pkg::t_rgba    r_p4;
    logic              r_act4;
    logic [1:0]        r_lo4;
    logic [1:0]        r_hi4;
    logic [7:0]        r_mn4;
    logic [7:0]        r_mx4;
    hsb_pkg::t_rgba    n_p4;
    logic [1:0]        n_lo4;
    logic [1:0]        n_hi4;
    logic [7:0]        n_mn4;
    logic [7:0]        n_mx4;
    logic              w_hzero;

    // Sextant pre-step and the e*D product.
    logic              r_v5;
    hsb_pkg::t_rgba    r_p5;
    logic              r_act5;
    logic [1:0]        r_mv5;
    logic [1:0]        r_ex5;
    logic              r_up5;
    logic [15:0]       r_prod5;
    logic [7:0]        r_mn5;
    logic [7:0]        r_mx5;
    hsb_pkg::t_rgba    n_p5;
    logic [1:0]        n_mv5;
    logic [1:0]        n_ex5;
    logic              n_up5;
    logic [1:0]        w_n1;
    logic [1:0]        w_n2;

    // Shifted numerator and reflection.
    logic              r_v6;
    hsb_pkg::t_rgba    r_p6;
    logic              r_act6;
    logic [1:0]        r_mv6;
    logic [1:0]        r_ex6;
    logic              r_over6;
    logic [15:0]       r_num6;
    logic [7:0]        r_bnd6;
    logic [7:0]        w_v;
    logic [7:0]        w_bnd;
    logic [15:0]       w_v255;
    logic [15:0]       w_b255;
    logic signed [18:0] w_n;
    logic              n_over6;
    logic [15:0]       n_num6;

    // Divide by 255 and write back.
    logic              r_v7;
    hsb_pkg::t_pix_out r_out7;
    hsb_pkg::t_rgba    n_p7;
    logic [16:0]       w_q;

    assign w_hzero = (i_ctrl.hue_ofs == 9'd0) && (i_ctrl.hue_sector == 2'd0);

    always_comb begin
        n_p4 = i_pix;
        unique case (i_ctrl.hue_sector)
            2'd1:    n_p4.ch = {i_pix.ch[1], i_pix.ch[0], i_pix.ch[2]};
            2'd2:    n_p4.ch = {i_pix.ch[0], i_pix.ch[2], i_pix.ch[1]};
            default: n_p4.ch = i_pix.ch;
        endcase
        n_mn4 = n_p4.ch[0];
        n_mx4 = n_p4.ch[1];
        n_lo4 = 2'd0;
        n_hi4 = 2'd1;
        if (n_p4.ch[1] < n_p4.ch[0]) begin
            n_mn4 = n_p4.ch[1];
            n_mx4 = n_p4.ch[0];
            n_lo4 = 2'd1;
            n_hi4 = 2'd0;
        end
        if (n_p4.ch[2] < n_mn4) begin
            n_mn4 = n_p4.ch[2];
            n_lo4 = 2'd2;
        end else if (n_p4.ch[2] > n_mx4) begin
            n_mx4 = n_p4.ch[2];
            n_hi4 = 2'd2;
        end
    end

    always_comb begin
        unique case (r_lo4)
            2'd1:    begin w_n1 = 2'd2; w_n2 = 2'd0; end
            2'd2:    begin w_n1 = 2'd0; w_n2 = 2'd1; end
            default: begin w_n1 = 2'd1; w_n2 = 2'd2; end
        endcase
        n_p5 = r_p4;
        if (!i_ctrl.hue_ofs[8]) begin
            if (w_n1 == r_hi4) begin
                n_mv5 = w_n2; n_ex5 = r_hi4; n_up5 = 1'b1;
            end else begin
                n_mv5 = w_n1; n_ex5 = r_lo4; n_up5 = 1'b0;
            end
        end else begin
            // A full sextant step first, then the partial shift the other way.
            if (w_n1 == r_hi4) begin
                n_p5.ch[r_hi4] = r_mn4 + r_mx4 - r_p4.ch[w_n2];
                n_p5.ch[w_n2]  = r_mx4;
                n_mv5 = w_n1; n_ex5 = r_lo4; n_up5 = 1'b0;
            end else begin
                n_p5.ch[r_lo4] = r_mx4 + r_mn4 - r_p4.ch[w_n1];
                n_p5.ch[w_n1]  = r_mn4;
                n_mv5 = r_lo4; n_ex5 = r_hi4; n_up5 = 1'b1;
            end
        end
    end

    always_comb begin
        w_v    = r_p5.ch[r_mv5];
        w_bnd  = r_up5 ? r_mx5 : r_mn5;
        w_v255 = {w_v, 8'd0} - 16'(w_v);
        w_b255 = {w_bnd, 8'd0} - 16'(w_bnd);
        if (r_up5) begin
            w_n     = 19'(w_v255) + 19'(r_prod5);
            n_over6 = w_n > $signed(19'(w_b255));
        end else begin
            w_n     = 19'(w_v255) - 19'(r_prod5);
            n_over6 = w_n < $signed(19'(w_b255));
        end
        // Past the bound the excess reflects; the result stays within max*255.
        if (n_over6) begin
            n_num6 = 16'({w_b255, 1'b0} - 17'(w_n));
        end else begin
            n_num6 = 16'(w_n);
        end
    end

    always_comb begin
        w_q  = (17'(r_num6) + 17'd1 + 17'(r_num6[15:8])) >> 8;
        n_p7 = r_p6;
        if (r_act6) begin
            if (r_over6) begin
                n_p7.ch[r_ex6] = w_q[7:0];
                n_p7.ch[r_mv6] = r_bnd6;
            end else begin
                n_p7.ch[r_mv6] = w_q[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
        if (i_en) begin
            r_p4    <= (i_ctrl.bypass || w_hzero || i_grey) ? i_pix : n_p4;
            r_act4  <= !(i_ctrl.bypass || w_hzero || i_grey);
            r_lo4   <= n_lo4;
            r_hi4   <= n_hi4;
            r_mn4   <= n_mn4;
            r_mx4   <= n_mx4;

            r_p5    <= r_act4 ? n_p5 : r_p4;
            r_act5  <= r_act4;
            r_mv5   <= n_mv5;
            r_ex5   <= n_ex5;
            r_up5   <= n_up5;
            r_prod5 <= i_ctrl.hue_ofs[7:0] * (r_mx4 - r_mn4);
            r_mn5   <= r_mn4;
            r_mx5   <= r_mx4;

            r_p6    <= r_p5;
            r_act6  <= r_act5;
            r_mv6   <= r_mv5;
            r_ex6   <= r_ex5;
            r_over6 <= n_over6;
            r_num6  <= n_num6;
            r_bnd6  <= w_bnd;

            r_out7.red_out   <= n_p7.ch[0];
            r_out7.green_out <= n_p7.ch[1];
            r_out7.blue_out  <= n_p7.ch[2];
            r_out7.alpha_out <= n_p7.alpha;
        end
    end

    assign o_valid = r_v7;
    assign o_pix   = r_out7;

endmodule

### rtl/pixel_hue_saturation_brightness.sv
// Throughput: one pixel per cycle; the seven register stages advance together
// and all hold while the output is stalled with a valid pixel waiting.
// Reset (synchronous, active low) clears every stage valid bit and sets all
// three adjustment registers to zero, which passes pixels through unchanged.
module pixel_hue_saturation_brightness (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  hsb_pkg::t_pix_in                    i_pix,
    output logic                                o_valid,
    input  logic                                i_stall,
    output hsb_pkg::t_pix_out                   o_pix,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [hsb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic               r_bright_zero;
    logic signed [7:0]  r_bright;
    logic [7:0]         r_desat;
    logic [1:0]         r_hue_sector;
    logic [8:0]         r_hue_ofs;
    logic [14:0]        w_q3;
    logic [6:0]         w_hi;
    logic [6:0]         w_sec;
    logic               w_en;
    hsb_pkg::t_ctrl     w_ctrl;
    logic               w_v1;
    hsb_pkg::t_rgba     w_p1;
    logic               w_v3;
    logic               w_grey3;
    hsb_pkg::t_rgba     w_p3;

    // hue_shift mod 1536: low nine bits plus (hue_shift / 512) mod 3.
    assign w_hi  = i_cfg_data[15:9];
    assign w_q3  = w_hi * 8'd171;
    assign w_sec = w_hi - 7'(3 * w_q3[14:9]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright      <= '0;
            r_bright_zero <= 1'b1;
            r_desat       <= '0;
            r_hue_sector  <= '0;
            r_hue_ofs     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsb_pkg::CFG_HUE_SHIFT: begin
                    r_hue_ofs    <= i_cfg_data[8:0];
                    r_hue_sector <= w_sec[1:0];
                end
                hsb_pkg::CFG_DESATURATION: r_desat <= i_cfg_data[7:0];
                hsb_pkg::CFG_BRIGHTNESS: begin
                    r_bright      <= i_cfg_data[7:0];
                    r_bright_zero <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign w_ctrl.bypass     = (r_bright == 8'sd127) || (r_bright == -8'sd128) ||
                               (r_desat == 8'd0);
    assign w_ctrl.desat      = r_desat;
    assign w_ctrl.hue_sector = r_hue_sector;
    assign w_ctrl.hue_ofs    = r_hue_ofs;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    hsb_bright u_bright (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_pix    (i_pix),
        .i_bright (r_bright_zero ? 8'sd0 : r_bright),
        .o_valid  (w_v1),
        .o_pix    (w_p1)
    );

    hsb_desat u_desat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctrl  (w_ctrl),
        .i_valid (w_v1),
        .i_pix   (w_p1),
        .o_valid (w_v3),
        .o_grey  (w_grey3),
        .o_pix   (w_p3)
    );

    hsb_hue u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctrl  (w_ctrl),
        .i_valid (w_v3),
        .i_grey  (w_grey3),
        .i_pix   (w_p3),
        .o_valid (o_valid),
        .o_pix   (o_pix)
    );

endmodule
